[hw/rtl/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cursor writer
// Screen size defaults, control codes, operation modes, FSM states and the
// control bundle that the cursor unit hands to the top level.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int TAB_STOP    = 4;

	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;

	typedef enum logic [1:0] {
		MODE_PRINT = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FLUSH
	} state_t;

	// decoded effect of one printed code
	typedef struct packed {
		logic wr_char;   // store char/colour at the old cursor
		logic bs_clear;  // backspace moved: zero the char byte of the new cell
		logic scroll;    // row hit the bottom: shift the screen up
	} step_ctl_t;

endpackage

[hw/rtl/text_console_cursor_writer.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_writer: text-mode screen store with cursor
// Keeps COLUMNS x ROWS cells (attribute in the high byte, character in the
// low byte) in one synchronous RAM and a cursor in registers. Prints codes,
// clears the screen, reads back single cells, reports the cursor each time.
// ----------------------------------------------------------------------------
//
//  channel | ports                                    | transfer
//  --------+------------------------------------------+--------------------------
//  command | start, busy, mode, char_code, colour,    | start & !busy at clk rise
//          | cell_index                               |
//  result  | done, cursor_offset, cursor_column,      | done high for one cycle,
//          | cursor_row, cell_char, cell_colour       | taken at the edge ending it
//
// Path (command transfer to the edge where done is taken):
//   plain print, tab, CR, LF, mode 3, out-of-range read: report registered straight away
//   backspace that moves, cell read: through READ for the RAM read
//   print that scrolls: SCROLL walks every cell with one RAM port pair, then FLUSH
//   clear screen: CLEAR writes each cell once, then the report
// After reset the same clearing pass runs with busy high. The receiver cannot
// stall: done is a one-cycle strobe, and a new command may transfer in the
// same cycle that done is up.

module text_console_cursor_writer #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  char_code,
	input  logic [7:0]  colour,
	input  logic [10:0] cell_index,

	output logic        done,
	output logic [10:0] cursor_offset,
	output logic [6:0]  cursor_column,
	output logic [4:0]  cursor_row,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_colour
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	// cells below this index are refilled from one row down during a scroll,
	// the last two rows are wiped
	localparam int COPY_END   = (ROWS - 2) * COLUMNS;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

	// ---------------------------------------------------------------- state
	tccw_pkg::state_t state_q, state_d;

	logic [COL_W-1:0]  col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;      // sweep pointer for clear / scroll
	logic              is_read_q;         // READ state serves a cell read
	logic              clr_res_q;         // clearing pass owes a result

	// scroll write stage
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              zero_s1;

	// cell RAM
	logic [15:0]       mem [CELL_COUNT];
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [15:0]       mem_wdata;
	logic [15:0]       rdata_q;

	// result registers
	logic        done_q;
	logic [10:0] offset_q;
	logic [6:0]  column_q;
	logic [4:0]  row_out_q;
	logic [7:0]  char_q, colour_q;

	// ---------------------------------------------------------------- decode
	logic                accept;
	logic                is_print, is_clear, is_read;
	logic                in_range;
	logic                ptr_last;
	logic                copy;
	logic                finish;
	logic [ADDR_W-1:0]   cur_addr;
	logic [ADDR_W-1:0]   new_offset;
	logic [COL_W-1:0]    step_col;
	logic [ROW_W-1:0]    step_row;
	tccw_pkg::step_ctl_t step_ctl;

	assign busy     = state_q != tccw_pkg::ST_IDLE;
	assign accept   = start & ~busy;
	assign is_print = mode == tccw_pkg::MODE_PRINT;
	assign is_clear = mode == tccw_pkg::MODE_CLEAR;
	assign is_read  = mode == tccw_pkg::MODE_READ;
	assign in_range = 32'(cell_index) < CELL_COUNT;
	assign ptr_last = ptr_q == LAST_ADDR;
	assign copy     = 32'(ptr_q) < COPY_END;
	assign cur_addr = ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q);

	tccw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.col      (col_q),
		.row      (row_q),
		.code     (char_code),
		.col_next (step_col),
		.row_next (step_row),
		.ctl      (step_ctl)
	);

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tccw_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_print) begin
						if (step_ctl.bs_clear)
							state_d = tccw_pkg::ST_READ;
						else if (step_ctl.scroll)
							state_d = tccw_pkg::ST_SCROLL;
					end else if (is_clear) begin
						state_d = tccw_pkg::ST_CLEAR;
					end else if (is_read && in_range) begin
						state_d = tccw_pkg::ST_READ;
					end
				end
			end
			tccw_pkg::ST_READ:   state_d = tccw_pkg::ST_IDLE;
			tccw_pkg::ST_SCROLL: if (ptr_last) state_d = tccw_pkg::ST_FLUSH;
			tccw_pkg::ST_FLUSH:  state_d = tccw_pkg::ST_IDLE;
			tccw_pkg::ST_CLEAR:  if (ptr_last) state_d = tccw_pkg::ST_IDLE;
			default:             state_d = tccw_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- outputs of FSM
	always_comb begin
		finish    = 1'b0;
		col_d     = col_q;
		row_d     = row_q;
		ptr_d     = ptr_q;
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = cur_addr - 1'b1;   // backspace target
		unique case (state_q)
			tccw_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_print) begin
						col_d = step_col;
						row_d = step_row;
						// plain character goes to the cell under the old cursor
						mem_we    = step_ctl.wr_char;
						mem_wdata = {colour, char_code};
						mem_re    = step_ctl.bs_clear;
						finish    = ~step_ctl.bs_clear & ~step_ctl.scroll;
					end else if (is_clear) begin
						col_d = '0;
						row_d = '0;
					end else if (is_read) begin
						mem_re    = in_range;
						mem_raddr = ADDR_W'(cell_index);
						finish    = ~in_range;
					end else begin
						finish = 1'b1;
					end
				end
			end
			tccw_pkg::ST_READ: begin
				// backspace: cursor already points at the cell, keep its colour
				mem_we    = ~is_read_q;
				mem_wdata = {rdata_q[15:8], 8'h00};
				finish    = 1'b1;
			end
			tccw_pkg::ST_SCROLL: begin
				mem_re    = copy;
				mem_raddr = ADDR_W'(32'(ptr_q) + COLUMNS);
				ptr_d     = ptr_last ? '0 : ptr_q + 1'b1;
			end
			tccw_pkg::ST_FLUSH: begin
				finish = 1'b1;
			end
			tccw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				ptr_d     = ptr_last ? '0 : ptr_q + 1'b1;
				finish    = ptr_last & clr_res_q;
			end
			default: ;
		endcase

		// scroll write stage: moved cell, or zero for the wiped rows
		if (valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s1;
			mem_wdata = zero_s1 ? '0 : rdata_q;
		end
	end

	assign new_offset = ADDR_W'(row_d * COLUMNS) + ADDR_W'(col_d);

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tccw_pkg::ST_CLEAR;
			col_q     <= '0;
			row_q     <= '0;
			ptr_q     <= '0;
			is_read_q <= 1'b0;
			clr_res_q <= 1'b0;
			valid_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			row_q    <= row_d;
			ptr_q    <= ptr_d;
			valid_s1 <= state_q == tccw_pkg::ST_SCROLL;
			done_q   <= finish;
			if (accept) begin
				is_read_q <= is_read;
				clr_res_q <= is_clear;
			end
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		zero_s1 <= ~copy;
		if (finish) begin
			offset_q  <= 11'(new_offset);
			column_q  <= 7'(col_d);
			row_out_q <= 5'(row_d);
			if (state_q == tccw_pkg::ST_READ && is_read_q) begin
				char_q   <= rdata_q[7:0];
				colour_q <= rdata_q[15:8];
			end else begin
				char_q   <= '0;
				colour_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- cell RAM
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	assign done          = done_q;
	assign cursor_offset = offset_q;
	assign cursor_column = column_q;
	assign cursor_row    = row_out_q;
	assign cell_char     = char_q;
	assign cell_colour   = colour_q;

endmodule

[hw/rtl/tccw_cursor.sv]
// ----------------------------------------------------------------------------
// tccw_cursor: cursor step unit
// Works out the cursor after one printed code: tab, CR, LF, backspace, wrap
// at the right edge and the bottom-row scroll, plus what the store must do.
// ----------------------------------------------------------------------------
module tccw_cursor #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF,
	localparam int COL_W  = $clog2(COLUMNS),
	localparam int ROW_W  = $clog2(ROWS)
) (
	input  logic [COL_W-1:0]    col,
	input  logic [ROW_W-1:0]    row,
	input  logic [7:0]          code,
	output logic [COL_W-1:0]    col_next,
	output logic [ROW_W-1:0]    row_next,
	output tccw_pkg::step_ctl_t ctl
);

	localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(tccw_pkg::TAB_STOP - 1));

	logic [COL_W:0]   col_w;   // one spare bit: tab/advance may pass the edge
	logic [COL_W:0]   col_x;
	logic [ROW_W-1:0] row_x;
	logic [ROW_W-1:0] row_w;
	logic             wrap;

	always_comb begin
		col_w        = {1'b0, col};
		col_x        = col_w;
		row_x        = row;
		ctl.wr_char  = 1'b0;
		ctl.bs_clear = 1'b0;
		case (code)
			tccw_pkg::CODE_BS: begin
				if (col != '0) begin
					col_x        = col_w - 1'b1;
					ctl.bs_clear = 1'b1;
				end
			end
			tccw_pkg::CODE_TAB: col_x = (col_w + (COL_W+1)'(tccw_pkg::TAB_STOP)) & TAB_MASK;
			tccw_pkg::CODE_CR:  col_x = '0;
			tccw_pkg::CODE_LF: begin
				col_x = '0;
				row_x = row + 1'b1;
			end
			default: begin
				col_x       = col_w + 1'b1;
				ctl.wr_char = 1'b1;
			end
		endcase

		wrap     = col_x >= (COL_W+1)'(COLUMNS);
		col_next = wrap ? '0 : col_x[COL_W-1:0];
		row_w    = wrap ? row_x + 1'b1 : row_x;

		ctl.scroll = row_w >= ROW_W'(ROWS - 1);
		row_next   = ctl.scroll ? ROW_W'(ROWS - 2) : row_w;
	end

endmodule

[tb/console_mirror_pkg.sv]
// ----------------------------------------------------------------------------
// console_mirror_pkg: screen and cursor mirror for the console writer bench
// Holds a copy of the text cells and the cursor. It predicts the report of
// every command and checks the reports that the block sends back.
// ----------------------------------------------------------------------------
package console_mirror_pkg;

	import tccw_pkg::*;

	localparam int COLS       = COLUMNS_DEF;
	localparam int LINES      = ROWS_DEF;
	localparam int CELL_COUNT = COLS * LINES;

	// mode code that the block must ignore
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [10:0] offset;
		logic [6:0]  column;
		logic [4:0]  row;
		logic [7:0]  char_byte;
		logic [7:0]  attr_byte;
	} cursor_report_t;

	class screen_mirror;
		logic [15:0]    cells [0:CELL_COUNT-1];
		int unsigned    col;
		int unsigned    row;
		cursor_report_t awaited[$];
		int unsigned    mismatches;
		int unsigned    commands;
		int unsigned    checked;
		int unsigned    scrolls;
		int unsigned    clears;
		int unsigned    reads;

		function new();
			wipe(0, CELL_COUNT);
			col = 0;
			row = 0;
		endfunction

		function void wipe(int unsigned first, int unsigned last_excl);
			for (int unsigned i = first; i < last_excl; i++) cells[i] = 16'h0000;
		endfunction

		// shift everything up one line, blank the two bottom lines
		function void scroll_up();
			for (int unsigned i = 0; i < COLS * (LINES - 1); i++) cells[i] = cells[i + COLS];
			wipe((LINES - 2) * COLS, CELL_COUNT);
			if (row >= 1) row--;
			else col = 0;
			scrolls++;
		endfunction

		function void print_code(logic [7:0] code, logic [7:0] attr);
			int unsigned at;
			at = row * COLS + col;
			case (code)
				CODE_BS: begin
					// only the char byte goes, the attribute stays
					if (col > 0) begin
						col--;
						at = row * COLS + col;
						if (at < CELL_COUNT) cells[at][7:0] = 8'h00;
					end
				end
				CODE_TAB: col = (col + TAB_STOP) / TAB_STOP * TAB_STOP;
				CODE_CR:  col = 0;
				CODE_LF: begin
					col = 0;
					row++;
				end
				default: begin
					if (at < CELL_COUNT) cells[at] = {attr, code};
					col++;
				end
			endcase
			if (col >= COLS) begin
				col = 0;
				row++;
			end
			if (row >= LINES - 1) scroll_up();
		endfunction

		// one transfer on the command side: predict its report
		function void take_command(logic [1:0] op, logic [7:0] code, logic [7:0] attr,
			logic [10:0] idx);
			cursor_report_t want;
			want = '0;
			case (op)
				MODE_PRINT: print_code(code, attr);
				MODE_CLEAR: begin
					wipe(0, CELL_COUNT);
					col = 0;
					row = 0;
					clears++;
				end
				MODE_READ: begin
					reads++;
					if (idx < CELL_COUNT) {want.attr_byte, want.char_byte} = cells[idx];
				end
				default: ;
			endcase
			want.offset = 11'(row * COLS + col);
			want.column = 7'(col);
			want.row    = 5'(row);
			awaited.push_back(want);
			commands++;
		endfunction

		function void compare(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", what, want, got);
				mismatches++;
			end
		endfunction

		// one transfer on the result side
		function void check_result(cursor_report_t got);
			cursor_report_t want;
			if (awaited.size() == 0) begin
				$error("result with no command outstanding: offset %0d", got.offset);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			compare("cursor_offset", want.offset, got.offset);
			compare("cursor_column", want.column, got.column);
			compare("cursor_row", want.row, got.row);
			compare("cell_char", want.char_byte, got.char_byte);
			compare("cell_colour", want.attr_byte, got.attr_byte);
		endfunction
	endclass

endpackage

[tb/text_console_cursor_writer_tb.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_writer_tb: self-checking bench for the console writer
// Sends a directed set of commands, then random runs of text, line feeds,
// tabs, backspaces, cell reads, clears and unused-mode noise. Every report
// is checked against a mirror of the screen and cursor.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_tb;

	import tccw_pkg::*;
	import console_mirror_pkg::*;

	// run length and limits
	localparam int unsigned TOTAL_ITEMS   = 440;
	localparam int unsigned CALM_FIRST    = 170;  // no sender idling from here ...
	localparam int unsigned CALM_LAST     = 320;  // ... up to, not including, here
	localparam int unsigned IDLE_PERCENT  = 11;
	localparam int unsigned DRAIN_CYCLES  = CELL_COUNT + 16;
	// worst case: every command scrolls (a walk over every cell) plus
	// sender gaps and the clearing pass after reset, taken about four times
	localparam int unsigned CYCLE_LIMIT   = 4_000_000;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        busy;
	logic [1:0]  mode        = MODE_PRINT;
	logic [7:0]  char_code   = 8'h00;
	logic [7:0]  colour      = 8'h00;
	logic [10:0] cell_index  = 11'd0;
	logic        done;
	logic [10:0] cursor_offset;
	logic [6:0]  cursor_column;
	logic [4:0]  cursor_row;
	logic [7:0]  cell_char;
	logic [7:0]  cell_colour;

	screen_mirror mirror;
	bit           idle_enable = 1'b1;
	int unsigned  items_sent  = 0;

	always #5 clk = ~clk;

	text_console_cursor_writer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.char_code     (char_code),
		.colour        (colour),
		.cell_index    (cell_index),
		.done          (done),
		.cursor_offset (cursor_offset),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.cell_char     (cell_char),
		.cell_colour   (cell_colour)
	);

	// One command transfer. Called and left at a falling edge. The sender
	// may idle first; start then stays up until an edge sees busy low.
	task automatic send_command(logic [1:0] op, logic [7:0] code, logic [7:0] attr,
		logic [10:0] idx);
		if (idle_enable) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start      <= 1'b1;
		mode       <= op;
		char_code  <= code;
		colour     <= attr;
		cell_index <= idx;
		do @(posedge clk); while (busy);
		// transfer taken at this edge
		mirror.take_command(op, code, attr, idx);
		items_sent++;
		@(negedge clk);
	endtask

	// Result side: done is a one-cycle strobe, sampled at the rising edge
	// that ends its cycle. The receiver has no way to stall.
	always @(posedge clk) begin
		if (arst_n && done)
			mirror.check_result({cursor_offset, cursor_column, cursor_row,
				cell_char, cell_colour});
	end

	// Watchdog: a run that has not ended by the limit is a failure.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("text_console_cursor_writer_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned kind;
		int unsigned n;
		int unsigned here;
		int unsigned back;
		logic [10:0] idx_pick;

		mirror = new();

		// single reset at the start; the block then runs its clearing pass
		// with busy high, so the first transfer simply waits for it
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// fresh screen reads as zero, both ends of the store and beyond
		send_command(MODE_READ, 8'h00, 8'h00, 11'd0);
		send_command(MODE_READ, 8'h00, 8'h00, 11'(CELL_COUNT - 1));
		send_command(MODE_READ, 8'h00, 8'h00, 11'(CELL_COUNT));
		send_command(MODE_READ, 8'hFF, 8'hFF, 11'h7FF);
		// backspace in column zero leaves everything alone
		send_command(MODE_PRINT, CODE_BS, 8'hFF, 11'd0);
		// printable extremes of char and attribute
		send_command(MODE_PRINT, 8'h41, 8'hFF, 11'd0);
		send_command(MODE_PRINT, 8'h00, 8'h5A, 11'h7FF);
		send_command(MODE_PRINT, 8'hFF, 8'h81, 11'd0);
		send_command(MODE_READ, 8'h00, 8'h00, 11'd0);
		send_command(MODE_READ, 8'h00, 8'h00, 11'd1);
		// backspace that moves drops the char byte, keeps the attribute
		send_command(MODE_PRINT, CODE_BS, 8'h00, 11'd0);
		send_command(MODE_READ, 8'h00, 8'h00, 11'd2);
		send_command(MODE_PRINT, CODE_TAB, 8'h00, 11'd0);
		send_command(MODE_PRINT, CODE_TAB, 8'hFF, 11'd0);
		send_command(MODE_PRINT, CODE_CR, 8'h00, 11'd0);
		send_command(MODE_PRINT, CODE_LF, 8'h00, 11'd0);
		// unused mode with every other bit set: cursor only, no change
		send_command(MODE_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
		send_command(MODE_PRINT, 8'h7A, 8'h0F, 11'd0);
		send_command(MODE_READ, 8'h00, 8'h00, 11'(COLS));
		send_command(MODE_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
		send_command(MODE_READ, 8'h00, 8'h00, 11'd0);
		send_command(MODE_READ, 8'h00, 8'h00, 11'(COLS));

		// ---- random part: runs of well-formed console traffic ----
		while (items_sent < TOTAL_ITEMS) begin
			idle_enable = !(items_sent >= CALM_FIRST && items_sent < CALM_LAST);
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// a run of text, usually ended by a line feed or a carriage return
				n = $urandom_range(1, 30);
				repeat (n)
					send_command(MODE_PRINT, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
				case ($urandom_range(0, 3))
					0, 1: send_command(MODE_PRINT, CODE_LF, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
					2: send_command(MODE_PRINT, CODE_CR, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
					default: ;
				endcase
			end else if (kind < 52) begin
				// line feeds push the cursor to the bottom and scroll there
				n = $urandom_range(1, 6);
				repeat (n)
					send_command(MODE_PRINT, CODE_LF, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
			end else if (kind < 62) begin
				// tab runs long enough to run off the end of a line
				n = $urandom_range(1, 21);
				repeat (n)
					send_command(MODE_PRINT, CODE_TAB, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
			end else if (kind < 70) begin
				n = $urandom_range(1, 6);
				repeat (n)
					send_command(MODE_PRINT, CODE_BS, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)));
			end else if (kind < 90) begin
				// reads: anywhere, just behind the cursor, or past the store
				n = $urandom_range(1, 4);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: idx_pick = 11'($urandom_range(0, CELL_COUNT - 1));
						1: idx_pick = 11'($urandom_range(CELL_COUNT, 2047));
						default: begin
							here = mirror.row * COLS + mirror.col;
							back = $urandom_range(0, 4);
							idx_pick = 11'((here > back) ? here - back : 0);
						end
					endcase
					send_command(MODE_READ, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), idx_pick);
				end
			end else if (kind < 95) begin
				send_command(MODE_UNUSED, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end else if (kind < 97) begin
				send_command(MODE_CLEAR, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end else begin
				// noise: any mode, any fields
				send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end
		end
		start <= 1'b0;

		// every command reports once; wait for the last one, then watch a
		// full scroll time for stray strobes
		while (mirror.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d commands, %0d reports checked, %0d mismatches",
			mirror.commands, mirror.checked, mirror.mismatches);
		$display("summary: %0d scrolls, %0d screen clears, %0d cell reads",
			mirror.scrolls, mirror.clears, mirror.reads);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
			$display("text_console_cursor_writer_tb: PASS");
		end else begin
			$display("text_console_cursor_writer_tb: FAIL");
		end
		$finish;
	end

endmodule
